/* src/jzoef_pkg.sv */
// jzoef_pkg: shared types and constants of the joystick zero-offset filter
// no dependencies; used by jzoef_lane, jzoef_merge and the top level
`default_nettype none

package jzoef_pkg;

  localparam int unsigned AlphaW = 16;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TimeW = 64;
  localparam int unsigned IntervalW = 32;

  localparam logic [AlphaW-1:0] AlphaReset = 16'd13107;
  localparam logic [IntervalW-1:0] IntervalReset = 32'd200000;

  typedef enum logic {
    OP_SAMPLE   = 1'b0,
    OP_SET_MODE = 1'b1
  } op_e;

  typedef enum logic {
    REG_ALPHA    = 1'b0,
    REG_INTERVAL = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_RAW    = 1'b0,
    MODE_ZEROED = 1'b1
  } mode_e;

  typedef struct packed {
    logic  report;
    mode_e mode;
  } stage_t;

endpackage

`default_nettype wire

/* src/jzoef_lane.sv */
// jzoef_lane: one axis of the filter, offset removal and exponential average
// depends on jzoef_pkg for the alpha width
`default_nettype none

module jzoef_lane #(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 sample_en_i,
  input  wire logic                                 capture_en_i,
  input  wire logic                                 zero_mode_i,
  input  wire logic [SAMPLE_BITS-1:0]               sample_i,
  input  wire logic [jzoef_pkg::AlphaW-1:0]         alpha_i,
  output logic signed [SAMPLE_BITS:0]               rounded_o
);

  localparam int unsigned AvgW = SAMPLE_BITS + 1 + FRACTION_BITS;
  localparam int unsigned DiffW = AvgW + 1;
  localparam int unsigned ProdW = DiffW + jzoef_pkg::AlphaW + 1;
  localparam logic [SAMPLE_BITS-1:0] RawReset = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  logic [SAMPLE_BITS-1:0]           last_raw_q;
  logic [SAMPLE_BITS-1:0]           offset_q;
  logic signed [AvgW-1:0]           avg_q, avg_d;
  logic signed [SAMPLE_BITS:0]      cond_s;
  logic signed [DiffW-1:0]          diff_s;
  logic signed [jzoef_pkg::AlphaW:0] alpha_s;
  logic signed [ProdW-1:0]          prod_s;
  logic signed [ProdW-1:0]          biased_s;
  logic signed [ProdW-1:0]          step_s;
  logic [AvgW-1:0]                  mag;
  logic [AvgW-1:0]                  rmag;

  // conditioned sample, offset removed in zero mode
  always_comb begin
    if (zero_mode_i) begin
      cond_s = signed'({1'b0, sample_i}) - signed'({1'b0, offset_q});
    end else begin
      cond_s = signed'({1'b0, sample_i});
    end
  end

  // avg + round((alpha * (sample - avg)) / 2^16), ties toward plus infinity
  assign diff_s   = (DiffW'(cond_s) <<< FRACTION_BITS) - DiffW'(avg_q);
  assign alpha_s  = signed'({1'b0, alpha_i});
  assign prod_s   = alpha_s * diff_s;
  assign biased_s = prod_s + signed'(ProdW'(1) << (jzoef_pkg::AlphaW - 1));
  assign step_s   = biased_s >>> jzoef_pkg::AlphaW;
  assign avg_d    = avg_q + AvgW'(step_s);

  // snapshot value, half away from zero
  assign mag  = avg_q[AvgW-1] ? AvgW'(-avg_q) : AvgW'(avg_q);
  assign rmag = (mag + (AvgW'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
  assign rounded_o = avg_q[AvgW-1] ? -signed'(rmag[SAMPLE_BITS:0])
                                   : signed'(rmag[SAMPLE_BITS:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= RawReset;
      offset_q   <= '0;
      avg_q      <= '0;
    end else begin
      if (sample_en_i) begin
        last_raw_q <= sample_i;
        avg_q      <= avg_d;
      end
      if (capture_en_i) begin
        offset_q <= last_raw_q;
      end
    end
  end

endmodule

`default_nettype wire

/* src/jzoef_merge.sv */
// jzoef_merge: joins both lanes into the snapshot and the output register
// depends on jzoef_pkg for the stage struct
`default_nettype none

module jzoef_merge #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire jzoef_pkg::stage_t           stage_i,
  output logic                             in_ready_o,
  input  wire logic signed [SAMPLE_BITS:0] round_x_i,
  input  wire logic signed [SAMPLE_BITS:0] round_y_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic                             report_o,
  output logic signed [SAMPLE_BITS:0]      report_x_o,
  output logic signed [SAMPLE_BITS:0]      report_y_o,
  output jzoef_pkg::mode_e                 mode_o
);

  logic                        s1_valid_q, s1_valid_d;
  jzoef_pkg::stage_t           s1_q;
  logic                        s1_adv;
  logic                        out_valid_q, out_valid_d;
  logic                        out_report_q;
  logic signed [SAMPLE_BITS:0] out_x_q, out_y_q;
  jzoef_pkg::mode_e            out_mode_q;
  logic signed [SAMPLE_BITS:0] held_x_q, held_y_q;
  logic signed [SAMPLE_BITS:0] held_x_d, held_y_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign held_x_d = s1_q.report ? round_x_i : held_x_q;
  assign held_y_d = s1_q.report ? round_y_i : held_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_x_q    <= '0;
      held_y_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        held_x_q <= held_x_d;
        held_y_q <= held_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s1_q <= stage_i;
    end
    if (s1_adv) begin
      out_report_q <= s1_q.report;
      out_x_q      <= held_x_d;
      out_y_q      <= held_y_d;
      out_mode_q   <= s1_q.mode;
    end
  end

  assign out_valid_o = out_valid_q;
  assign report_o    = out_report_q;
  assign report_x_o  = out_x_q;
  assign report_y_o  = out_y_q;
  assign mode_o      = out_mode_q;

endmodule

`default_nettype wire

/* src/joystick_zero_offset_ema_filter.sv */
// joystick_zero_offset_ema_filter: top level, two filter lanes, timer and merge
// depends on jzoef_pkg, jzoef_lane and jzoef_merge
`default_nettype none

// Two-axis joystick conditioner. Each sample item updates an exponential
// average per axis (Y inverted, captured offsets removed in zeroed mode) and,
// once report_interval_us has passed since the last snapshot, latches the
// averages rounded half away from zero and flags a report. A set-mode item
// selects raw or zeroed mode; zeroed mode captures the last raw pair as the
// offsets. One item is taken every clock cycle unless the output stalls, and
// each item gives one result. The cycle is set by the average update of each
// lane (one 17 by 30 bit multiply and add feeding the average register) and
// by the 64-bit elapsed-time compare of the report timer. Configuration
// writes are always ready and are meant for times when no item is in flight.

module joystick_zero_offset_ema_filter #(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 16,
  localparam int unsigned InW = 2 * SAMPLE_BITS + jzoef_pkg::TimeW + 1,
  localparam int unsigned InTdataW = ((InW + 7) / 8) * 8,
  localparam int unsigned OutW = 2 * (SAMPLE_BITS + 1) + 1,
  localparam int unsigned OutTdataW = ((OutW + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic                            cfg_index_i,
  input  wire logic [jzoef_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // adc_x, adc_y, time_us, new_mode
  input  wire logic [InTdataW-1:0]             s_axis_tdata_i,
  // op
  input  wire logic                            s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // report_x, report_y, mode
  output logic [OutTdataW-1:0]                 m_axis_tdata_o,
  // report
  output logic                                 m_axis_tuser_o
);

  localparam int unsigned YLo = SAMPLE_BITS;
  localparam int unsigned TimeLo = 2 * SAMPLE_BITS;
  localparam int unsigned ModeBit = TimeLo + jzoef_pkg::TimeW;

  logic [jzoef_pkg::AlphaW-1:0]    alpha_q;
  logic [jzoef_pkg::IntervalW-1:0] interval_q;
  jzoef_pkg::mode_e                zero_mode_q, zero_mode_d;
  logic [jzoef_pkg::TimeW-1:0]     last_time_q;

  logic [SAMPLE_BITS-1:0]          adc_x, adc_y;
  logic [jzoef_pkg::TimeW-1:0]     time_us;
  logic                            new_mode;
  jzoef_pkg::op_e                  op;
  logic                            in_ready;
  logic                            in_fire, sample_fire, set_fire, capture;
  logic [jzoef_pkg::TimeW-1:0]     elapsed;
  logic                            report_d;
  jzoef_pkg::stage_t               stage;
  logic signed [SAMPLE_BITS:0]     round_x, round_y;
  logic signed [SAMPLE_BITS:0]     out_x, out_y;
  jzoef_pkg::mode_e                out_mode;

  assign adc_x    = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign adc_y    = s_axis_tdata_i[YLo +: SAMPLE_BITS];
  assign time_us  = s_axis_tdata_i[TimeLo +: jzoef_pkg::TimeW];
  assign new_mode = s_axis_tdata_i[ModeBit];
  assign op       = jzoef_pkg::op_e'(s_axis_tuser_i);

  assign in_fire     = s_axis_tvalid_i && in_ready;
  assign sample_fire = in_fire && (op == jzoef_pkg::OP_SAMPLE);
  assign set_fire    = in_fire && (op == jzoef_pkg::OP_SET_MODE);
  assign capture     = set_fire && new_mode;

  assign elapsed  = time_us - last_time_q;
  assign report_d = sample_fire && (elapsed >= jzoef_pkg::TimeW'(interval_q));

  always_comb begin
    zero_mode_d = zero_mode_q;
    if (set_fire) begin
      zero_mode_d = new_mode ? jzoef_pkg::MODE_ZEROED : jzoef_pkg::MODE_RAW;
    end
  end

  assign stage.report = report_d;
  assign stage.mode   = zero_mode_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= jzoef_pkg::AlphaReset;
      interval_q  <= jzoef_pkg::IntervalReset;
      zero_mode_q <= jzoef_pkg::MODE_RAW;
      last_time_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (jzoef_pkg::cfg_reg_e'(cfg_index_i))
          jzoef_pkg::REG_ALPHA:    alpha_q <= cfg_data_i[jzoef_pkg::AlphaW-1:0];
          jzoef_pkg::REG_INTERVAL: interval_q <= cfg_data_i[jzoef_pkg::IntervalW-1:0];
          default: ;
        endcase
      end
      zero_mode_q <= zero_mode_d;
      if (report_d) begin
        last_time_q <= time_us;
      end
    end
  end

  jzoef_lane #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_en_i (sample_fire),
    .capture_en_i(capture),
    .zero_mode_i (zero_mode_q == jzoef_pkg::MODE_ZEROED),
    .sample_i    (adc_x),
    .alpha_i     (alpha_q),
    .rounded_o   (round_x)
  );

  // y is inverted: full scale minus the reading
  jzoef_lane #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_en_i (sample_fire),
    .capture_en_i(capture),
    .zero_mode_i (zero_mode_q == jzoef_pkg::MODE_ZEROED),
    .sample_i    (~adc_y),
    .alpha_i     (alpha_q),
    .rounded_o   (round_y)
  );

  jzoef_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_fire),
    .stage_i    (stage),
    .in_ready_o (in_ready),
    .round_x_i  (round_x),
    .round_y_i  (round_y),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .report_o   (m_axis_tuser_o),
    .report_x_o (out_x),
    .report_y_o (out_y),
    .mode_o     (out_mode)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tdata_o  = OutTdataW'({out_mode, out_y, out_x});

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled while output register could drain");

  a_capture_sets_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> zero_mode_q == jzoef_pkg::MODE_ZEROED)
    else $error("offset capture did not enter zeroed mode");

  a_timer_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_d |=> last_time_q == $past(time_us))
    else $error("report did not restart the interval timer");

  a_timer_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !report_d |=> $stable(last_time_q))
    else $error("interval timer moved without a report");

endmodule

`default_nettype wire

/* dv/tb_joystick_zero_offset_ema_filter.sv */
// tb_joystick_zero_offset_ema_filter: self-checking testbench of the joystick filter
// predicts each result from its own copy of the filter state and compares fields
// depends on jzoef_pkg and joystick_zero_offset_ema_filter
`timescale 1ns / 100ps

module tb_joystick_zero_offset_ema_filter;

  localparam int unsigned SampleW = 12;
  localparam int unsigned FracBits = 16;
  localparam int unsigned InTdataW = ((2 * SampleW + jzoef_pkg::TimeW + 1 + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((2 * (SampleW + 1) + 1 + 7) / 8) * 8;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold = 150;

  typedef struct {
    jzoef_pkg::op_e   op;
    logic [11:0]      adc_x;
    logic [11:0]      adc_y;
    logic [63:0]      time_us;
    jzoef_pkg::mode_e new_mode;
  } joy_item_t;

  typedef struct {
    logic             report;
    logic [12:0]      pos_x;
    logic [12:0]      pos_y;
    jzoef_pkg::mode_e mode;
  } joy_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          cfg_valid = 1'b0;
  jzoef_pkg::cfg_reg_e           cfg_index = jzoef_pkg::REG_ALPHA;
  logic [jzoef_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                          cfg_ready;
  logic                          src_valid = 1'b0;
  logic                          src_ready;
  logic [InTdataW-1:0]           src_tdata = '0;
  logic                          src_tuser = 1'b0;
  logic                          snk_valid;
  logic                          sink_ready = 1'b0;
  logic [OutTdataW-1:0]          snk_tdata;
  logic                          snk_tuser;

  always #4 clk = ~clk;

  joystick_zero_offset_ema_filter u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(src_valid),
    .s_axis_tready_o(src_ready),
    .s_axis_tdata_i (src_tdata),
    .s_axis_tuser_i (src_tuser),
    .m_axis_tvalid_o(snk_valid),
    .m_axis_tready_i(sink_ready),
    .m_axis_tdata_o (snk_tdata),
    .m_axis_tuser_o (snk_tuser)
  );

  // filter state as the block should hold it
  logic [jzoef_pkg::AlphaW-1:0]    alpha_cur = jzoef_pkg::AlphaReset;
  logic [jzoef_pkg::IntervalW-1:0] interval_cur = jzoef_pkg::IntervalReset;
  int                              last_x = 2048;
  int                              last_y = 2048;
  int                              cap_x = 0;
  int                              cap_y = 0;
  jzoef_pkg::mode_e                mode_cur = jzoef_pkg::MODE_RAW;
  longint                          avg_x = 0;
  longint                          avg_y = 0;
  logic [63:0]                     snap_time = '0;
  logic [12:0]                     held_x = '0;
  logic [12:0]                     held_y = '0;

  joy_item_t   pending_items[$];
  joy_report_t report_q[$];
  int          items_queued = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  bit          quiet = 1'b0;
  logic [63:0] now_us = '0;

  function automatic longint ema_next(longint avg, int d);
    longint acc;
    acc = longint'(alpha_cur) * (longint'(d) <<< FracBits)
        + (64'sd65536 - longint'(alpha_cur)) * avg + 64'sd32768;
    return acc >>> 16;
  endfunction

  function automatic logic [12:0] round_half_away(longint avg);
    longint mag;
    mag = (avg < 0) ? -avg : avg;
    mag = (mag + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    return (avg < 0) ? 13'(-mag) : 13'(mag);
  endfunction

  function automatic joy_report_t filter_step(joy_item_t it);
    joy_report_t r;
    int dx;
    int dy;
    r.report = 1'b0;
    if (it.op == jzoef_pkg::OP_SAMPLE) begin
      last_x = int'(it.adc_x);
      last_y = 4095 - int'(it.adc_y);
      dx = last_x;
      dy = last_y;
      if (mode_cur == jzoef_pkg::MODE_ZEROED) begin
        dx = dx - cap_x;
        dy = dy - cap_y;
      end
      avg_x = ema_next(avg_x, dx);
      avg_y = ema_next(avg_y, dy);
      if (it.time_us - snap_time >= {32'd0, interval_cur}) begin
        held_x = round_half_away(avg_x);
        held_y = round_half_away(avg_y);
        snap_time = it.time_us;
        r.report = 1'b1;
      end
    end else if (it.new_mode == jzoef_pkg::MODE_ZEROED) begin
      mode_cur = jzoef_pkg::MODE_ZEROED;
      cap_x = last_x;
      cap_y = last_y;
    end else begin
      mode_cur = jzoef_pkg::MODE_RAW;
    end
    r.pos_x = held_x;
    r.pos_y = held_y;
    r.mode = mode_cur;
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // sender
  joy_item_t cur_item;
  int        src_gap = 0;
  logic      next_valid;

  always @(posedge clk) begin
    if (rst_n) begin
      if (src_valid && src_ready) report_q.push_back(filter_step(cur_item));
      if (!src_valid || src_ready) begin
        next_valid = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          next_valid = 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 11);
        end
        src_valid <= next_valid;
        if (next_valid) begin
          src_tdata <= InTdataW'({cur_item.new_mode, cur_item.time_us,
                                  cur_item.adc_y, cur_item.adc_x});
          src_tuser <= cur_item.op;
        end
      end
    end
  end

  // receiver
  int sink_hold = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!long_hold_done && results_seen >= 400) begin
      long_hold_done = 1'b1;
      sink_hold = LongHold;
    end else if (sink_hold == 0 && !quiet && $urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(1, 11);
    end
    if (sink_hold > 0) begin
      sink_hold--;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // result checker
  joy_report_t want_r;

  always @(posedge clk) begin
    if (rst_n && snk_valid && sink_ready) begin
      results_seen++;
      if (report_q.size() == 0) begin
        flag_mismatch("result with nothing expected", results_seen, 0);
      end else begin
        want_r = report_q.pop_front();
        if (snk_tuser !== want_r.report)
          flag_mismatch("report", snk_tuser, want_r.report);
        if (snk_tdata[12:0] !== want_r.pos_x)
          flag_mismatch("report_x", $signed(snk_tdata[12:0]), $signed(want_r.pos_x));
        if (snk_tdata[25:13] !== want_r.pos_y)
          flag_mismatch("report_y", $signed(snk_tdata[25:13]), $signed(want_r.pos_y));
        if (snk_tdata[26] !== want_r.mode)
          flag_mismatch("mode", snk_tdata[26], want_r.mode);
      end
    end
  end

  // watchdog
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (results_seen >= items_queued || (src_valid && src_ready) ||
        (snk_valid && sink_ready)) begin
      stuck_cycles = 0;
    end else if (++stuck_cycles >= StallLimit) begin
      $display("tb_joystick_zero_offset_ema_filter: done, errors");
      $finish;
    end
  end

  task automatic push_item(joy_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_sample(logic [11:0] x, logic [11:0] y, logic [63:0] t);
    joy_item_t it;
    it.op = jzoef_pkg::OP_SAMPLE;
    it.adc_x = x;
    it.adc_y = y;
    it.time_us = t;
    it.new_mode = jzoef_pkg::mode_e'($urandom_range(0, 1));
    push_item(it);
  endtask

  task automatic push_mode(jzoef_pkg::mode_e m);
    joy_item_t it;
    it.op = jzoef_pkg::OP_SET_MODE;
    it.adc_x = 12'($urandom);
    it.adc_y = 12'($urandom);
    it.time_us = {$urandom, $urandom};
    it.new_mode = m;
    push_item(it);
  endtask

  task automatic write_reg(jzoef_pkg::cfg_reg_e idx, logic [jzoef_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == jzoef_pkg::REG_ALPHA) alpha_cur = val[jzoef_pkg::AlphaW-1:0];
    else interval_cur = val;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_seen < items_queued);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_random(int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        push_mode(jzoef_pkg::mode_e'($urandom_range(0, 1)));
      end else begin
        kind = $urandom_range(0, 19);
        if (kind == 0) now_us = {$urandom, $urandom};
        else if (kind == 1) now_us = now_us + interval_cur;
        else if (kind == 2) now_us = now_us + interval_cur - 1;
        else now_us = now_us + $urandom_range(0, interval_cur / 3 + 1);
        push_sample(12'($urandom), 12'($urandom), now_us);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: extremes, wrap of the timer, zeroed mode and recapture
    push_sample(12'd0, 12'd0, 64'd0);
    push_sample(12'd4095, 12'd4095, 64'd199999);
    push_sample(12'd4095, 12'd0, 64'd200000);
    push_sample(12'd0, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
    push_sample(12'd2048, 12'd2047, 64'd5);
    push_mode(jzoef_pkg::MODE_ZEROED);
    push_sample(12'd0, 12'd4095, 64'h1_0000_0000);
    push_sample(12'd4095, 12'd0, 64'h2_0000_0000);
    push_mode(jzoef_pkg::MODE_ZEROED);
    push_sample(12'd0, 12'd4095, 64'h3_0000_0000);
    push_mode(jzoef_pkg::MODE_RAW);
    push_sample(12'hAAA, 12'h555, 64'h5555_5555_5555_5555);
    push_sample(12'h555, 12'hAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    wait_drained();

    write_reg(jzoef_pkg::REG_ALPHA, 32'd65535);
    write_reg(jzoef_pkg::REG_INTERVAL, 32'd0);
    push_sample(12'd4095, 12'd0, 64'd0);
    push_mode(jzoef_pkg::MODE_ZEROED);
    push_sample(12'd0, 12'd4095, 64'd0);
    wait_drained();

    // weight zero holds the averages
    write_reg(jzoef_pkg::REG_ALPHA, 32'd0);
    write_reg(jzoef_pkg::REG_INTERVAL, 32'd1);
    push_sample(12'd4095, 12'd4095, 64'd10);
    push_sample(12'd0, 12'd0, 64'd10);
    wait_drained();

    write_reg(jzoef_pkg::REG_ALPHA, 32'd1);
    write_reg(jzoef_pkg::REG_INTERVAL, 32'hFFFF_FFFF);
    push_sample(12'd4095, 12'd0, 64'hFFFF_FFFF_0000_0000);
    push_sample(12'd123, 12'd3210, 64'h0000_0000_FFFF_FFFF);
    wait_drained();

    now_us = 64'd1000;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 1) begin
        write_reg(jzoef_pkg::REG_ALPHA, 32'd65535);
        write_reg(jzoef_pkg::REG_INTERVAL, 32'hFFFF_FFFF);
      end else begin
        write_reg(jzoef_pkg::REG_ALPHA, $urandom_range(1, 65535));
        write_reg(jzoef_pkg::REG_INTERVAL, $urandom_range(0, 3) == 0 ?
                  $urandom_range(1, 200000) : $urandom_range(1, 1000));
      end
      if (phase == 4) quiet = 1'b1;
      run_random(phase == 0 ? 420 : 370);
      wait_drained();
    end

    if (report_q.size() != 0) flag_mismatch("results left over", report_q.size(), 0);
    if (mismatches == 0) begin
      $display("tb_joystick_zero_offset_ema_filter: done, clean");
    end else begin
      $display("tb_joystick_zero_offset_ema_filter: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/jzoef_pkg.sv
src/jzoef_lane.sv
src/jzoef_merge.sv
src/joystick_zero_offset_ema_filter.sv
dv/tb_joystick_zero_offset_ema_filter.sv
